>>> rtl/tlfs_pkg.sv
// Shared types and constants for the tag/length frame splitter.
// No dependencies; imported by every module of the block.
package tlfs_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_PAYLOAD = 2'd0;
    localparam kind_t KIND_EMPTY   = 2'd1;
    localparam kind_t KIND_ERROR   = 2'd2;

    // header_count runs 0..7 over the header, PAYLOAD_PHASE while forwarding
    localparam logic [3:0] PAYLOAD_PHASE = 4'd8;
    localparam logic [3:0] LAST_HDR_BYTE = 4'd7;

    localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;

    localparam int          APB_ADDR_W    = 3;
    localparam logic [0:0]  REG_MAX_LEN   = 1'd0;

endpackage

>>> rtl/tlfs_cfg_regs.sv
// APB-style register bank of the frame splitter: holds max_frame_length.
// Depends on tlfs_pkg.
module tlfs_cfg_regs
    import tlfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [31:0]           max_len
);

    logic [31:0] max_len_reg;
    logic        wr_en;
    logic [0:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else if (wr_en && (reg_idx == REG_MAX_LEN)) begin
            max_len_reg <= pwdata;
        end
    end

    always_comb begin
        if (reg_idx == REG_MAX_LEN) begin
            prdata = max_len_reg;
        end else begin
            prdata = 32'd0;
        end
    end

    assign max_len = max_len_reg;

endmodule

>>> rtl/tag_length_frame_splitter.sv
// Top level of the tag/length frame splitter: header gathering, payload
// forwarding and the result register. Depends on tlfs_pkg and tlfs_cfg_regs.

// Takes one stream byte per cycle and cuts it into frames of an 8-byte
// little-endian header (32-bit tag, 32-bit length) followed by the payload.
// Each payload byte is registered in the cycle after it is taken, with the frame's tag,
// length and first/last marks; a zero-length frame gives one empty-frame
// result, and a length above max_frame_length gives one error result after
// which every byte is dropped until reset. Throughput is one byte per cycle:
// the per-byte work is a byte insert, 32-bit compares and one 32-bit
// decrement between the state registers and a single result register, and
// s_tready stays high whenever that result register is empty or being taken.
module tag_length_frame_splitter
    import tlfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [71:0]           m_tdata,   // [31:0] frame_tag, [63:32] frame_length,
                                             // [71:64] payload_byte
    output logic [2:0]            m_tuser,   // [1:0] kind, [2] first_of_frame
    output logic                  m_tlast    // last_of_frame
);

    logic [31:0] max_len;

    tlfs_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .max_len (max_len)
    );

    logic [3:0]  hdr_cnt_reg,  hdr_cnt_next;
    logic [31:0] tag_reg,      tag_next;
    logic [31:0] len_reg,      len_next;
    logic [31:0] remain_reg,   remain_next;
    logic        broken_reg,   broken_next;

    logic        m_tvalid_reg;
    logic [71:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;
    logic        m_tlast_reg;

    logic        accept;
    logic        emit;
    kind_t       emit_kind;
    logic [7:0]  emit_byte;
    logic        emit_first;
    logic        emit_last;
    logic [4:0]  byte_pos;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign byte_pos = {hdr_cnt_reg[1:0], 3'b000};

    always_comb begin
        hdr_cnt_next = hdr_cnt_reg;
        tag_next     = tag_reg;
        len_next     = len_reg;
        remain_next  = remain_reg;
        broken_next  = broken_reg;
        emit         = 1'b0;
        emit_kind    = KIND_PAYLOAD;
        emit_byte    = 8'd0;
        emit_first   = 1'b0;
        emit_last    = 1'b0;

        if (accept && !broken_reg) begin
            if (hdr_cnt_reg != PAYLOAD_PHASE) begin
                if (!hdr_cnt_reg[2]) begin
                    tag_next[byte_pos +: 8] = s_tdata;
                end else begin
                    len_next[byte_pos +: 8] = s_tdata;
                end
                hdr_cnt_next = hdr_cnt_reg + 4'd1;
                if (hdr_cnt_reg == LAST_HDR_BYTE) begin
                    // decide the frame on its final header byte
                    if (len_next > max_len) begin
                        broken_next  = 1'b1;
                        hdr_cnt_next = 4'd0;
                        emit         = 1'b1;
                        emit_kind    = KIND_ERROR;
                    end else if (len_next == 32'd0) begin
                        hdr_cnt_next = 4'd0;
                        emit         = 1'b1;
                        emit_kind    = KIND_EMPTY;
                        emit_last    = 1'b1;
                    end else begin
                        remain_next  = len_next;
                        hdr_cnt_next = PAYLOAD_PHASE;
                    end
                end
            end else begin
                emit       = 1'b1;
                emit_kind  = KIND_PAYLOAD;
                emit_byte  = s_tdata;
                emit_first = (remain_reg == len_reg);
                emit_last  = (remain_reg <= 32'd1);
                if (remain_reg != 32'd0) begin
                    remain_next = remain_reg - 32'd1;
                end
                if (remain_reg <= 32'd1) begin
                    hdr_cnt_next = 4'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_cnt_reg <= 4'd0;
            tag_reg     <= 32'd0;
            len_reg     <= 32'd0;
            remain_reg  <= 32'd0;
            broken_reg  <= 1'b0;
        end else begin
            hdr_cnt_reg <= hdr_cnt_next;
            tag_reg     <= tag_next;
            len_reg     <= len_next;
            remain_reg  <= remain_next;
            broken_reg  <= broken_next;
        end
    end

    // result register: load on a producing request, clear once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= {emit_byte, len_next, tag_next};
            m_tuser_reg <= {emit_first, emit_kind};
            m_tlast_reg <= emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // once broken, no new result may appear
    assert property (@(posedge aclk) disable iff (!aresetn)
        (broken_reg && !m_tvalid_reg) |=> !m_tvalid_reg)
        else $error("result produced on a broken stream");

    assert property (@(posedge aclk) disable iff (!aresetn)
        hdr_cnt_reg <= PAYLOAD_PHASE)
        else $error("header count out of range");

    // payload phase always has bytes left to forward
    assert property (@(posedge aclk) disable iff (!aresetn)
        (hdr_cnt_reg == PAYLOAD_PHASE) |-> (remain_reg != 32'd0))
        else $error("payload phase with nothing remaining");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_tuser_reg[1:0] == KIND_ERROR))
            |-> (!m_tlast_reg && !m_tuser_reg[2] && broken_reg))
        else $error("malformed length error result");

endmodule

>>> sim/tb_tag_length_frame_splitter.sv
// Self-checking bench for tag_length_frame_splitter: byte stream in, frame results out.
// Depends on tlfs_pkg and the RTL of the block; an in-bench deframer predicts each result.
module tb_tag_length_frame_splitter;
    import tlfs_pkg::*;

    localparam int TIMEOUT = 400000;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] tag;
        logic [31:0] length;
        logic [7:0]  pbyte;
        logic        first;
        logic        last;
    } frame_result_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;   // [7:0] data_byte
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [71:0]           m_tdata;         // [31:0] tag, [63:32] length, [71:64] payload byte
    logic [2:0]            m_tuser;         // [1:0] kind, [2] first_of_frame
    logic                  m_tlast;         // last_of_frame

    logic [7:0]    stream_bytes_q[$];
    frame_result_t frame_results_q[$];

    // deframer state, mirrored from the block
    logic [3:0]  hdr_count;
    logic [31:0] hdr_tag;
    logic [31:0] hdr_len;
    logic [31:0] bytes_left;
    logic [31:0] max_len;
    logic        stream_broken;

    int            send_gap;
    int            send_calm;
    int            recv_gap;
    int            recv_calm;
    int            mismatch_count;
    logic [31:0]   final_max;
    frame_result_t seen;
    frame_result_t want;

    tag_length_frame_splitter DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Draws an idle wait, with the odd calm stretch of no waiting at all
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    function automatic void push_result(kind_t kind, logic [7:0] pbyte, logic first,
                                        logic last);
        frame_result_t r;
        r = '{kind, hdr_tag, hdr_len, pbyte, first, last};
        frame_results_q.insert(frame_results_q.size(), r);
    endfunction

    function automatic void deframe_byte(logic [7:0] b);
        if (stream_broken) begin
            // drop everything once the stream is broken
        end else if (hdr_count < PAYLOAD_PHASE) begin
            if (hdr_count < 4'd4)
                hdr_tag[{hdr_count[1:0], 3'b000} +: 8] = b;
            else
                hdr_len[{hdr_count[1:0], 3'b000} +: 8] = b;
            if (hdr_count != LAST_HDR_BYTE) begin
                hdr_count++;
            end else if (hdr_len > max_len) begin
                stream_broken = 1'b1;
                hdr_count = '0;
                push_result(KIND_ERROR, 8'h00, 1'b0, 1'b0);
            end else if (hdr_len == 32'd0) begin
                hdr_count = '0;
                push_result(KIND_EMPTY, 8'h00, 1'b0, 1'b1);
            end else begin
                bytes_left = hdr_len;
                hdr_count = PAYLOAD_PHASE;
            end
        end else begin
            push_result(KIND_PAYLOAD, b, bytes_left == hdr_len, bytes_left <= 32'd1);
            if (bytes_left > 32'd0)
                bytes_left--;
            if (bytes_left == 32'd0)
                hdr_count = '0;
        end
    endfunction

    // Request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            hdr_count     = '0;
            hdr_tag       = '0;
            hdr_len       = '0;
            bytes_left    = '0;
            max_len       = MAX_LEN_RESET;
            stream_broken = 1'b0;
            send_calm     = 0;
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                deframe_byte(s_tdata);
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (stream_bytes_q.size() != 0) begin
                s_tdata  <= stream_bytes_q[0];
                stream_bytes_q.delete(0);
                s_tvalid <= 1'b1;
                send_gap <= draw_wait(send_calm);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            recv_calm = 0;
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else if (m_tvalid && m_tready) begin
            seen = {m_tuser[1:0], m_tdata[31:0], m_tdata[63:32], m_tdata[71:64], m_tuser[2],
                    m_tlast};
            if (frame_results_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: kind=%0d tag=%h len=%h byte=%h first=%b last=%b",
                             seen.kind, seen.tag, seen.length, seen.pbyte, seen.first,
                             seen.last);
            end else begin
                want = frame_results_q[0];
                frame_results_q.delete(0);
                if (seen !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("mismatch: exp kind=%0d tag=%h len=%h byte=%h first=%b last=%b",
                                 want.kind, want.tag, want.length, want.pbyte, want.first,
                                 want.last);
                        $display("          got kind=%0d tag=%h len=%h byte=%h first=%b last=%b",
                                 seen.kind, seen.tag, seen.length, seen.pbyte, seen.first,
                                 seen.last);
                    end
                end
            end
            recv_gap = draw_wait(recv_calm);
            m_tready <= (recv_gap == 0);
        end else if (recv_gap > 0) begin
            m_tready <= (recv_gap == 1);
            recv_gap <= recv_gap - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic write_max_length(input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MAX_LEN, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        max_len = value;
        @(negedge aclk);
    endtask

    task automatic queue_header(input logic [31:0] tag, input logic [31:0] len);
        logic [63:0] hdr;
        hdr = {len, tag};
        for (int i = 0; i < 8; i++)
            stream_bytes_q.insert(stream_bytes_q.size(), hdr[i*8 +: 8]);
    endtask

    // fill < 0 gives random payload bytes
    task automatic queue_frame(input logic [31:0] tag, input logic [31:0] len, input int fill);
        queue_header(tag, len);
        for (int i = 0; i < len; i++)
            stream_bytes_q.insert(stream_bytes_q.size(),
                                  fill < 0 ? 8'($urandom) : 8'(fill));
    endtask

    task automatic queue_random_frames(input int byte_budget, input int longest);
        int          queued;
        logic [31:0] len;
        queued = 0;
        while (queued < byte_budget) begin
            if ($urandom_range(0, 3) == 0)
                len = $urandom_range(0, longest);
            else
                len = $urandom_range(0, (longest < 4) ? longest : 4);
            queue_frame($urandom, len, -1);
            queued += 8 + len;
        end
    endtask

    // Sample at the falling edge so the queues and handshakes have settled
    task automatic wait_idle();
        do @(negedge aclk);
        while (stream_bytes_q.size() != 0 || s_tvalid || frame_results_q.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        mismatch_count = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        write_max_length(32'hFFFF_FFFF);
        queue_frame(32'hFFFF_FFFF, 32'd0, -1);
        queue_random_frames(300, 16);
        wait_idle();

        // a length equal to the limit is still accepted
        write_max_length(32'd3);
        queue_frame(32'h0000_0000, 32'd3, 8'hFF);
        queue_random_frames(200, 3);
        wait_idle();

        write_max_length(32'd0);
        repeat (5) queue_frame($urandom, 32'd0, -1);
        wait_idle();

        write_max_length(MAX_LEN_RESET);
        queue_random_frames(220, 40);
        wait_idle();

        // one past the limit breaks the stream; the trailing noise must be dropped
        final_max = $urandom_range(1, 64);
        write_max_length(final_max);
        queue_random_frames(40, final_max);
        queue_header($urandom, final_max + 32'd1);
        repeat (24) stream_bytes_q.insert(stream_bytes_q.size(), 8'($urandom));
        wait_idle();
        repeat (8) @(posedge aclk);

        if (frame_results_q.size() != 0) begin
            mismatch_count++;
            $display("%0d expected results never arrived", frame_results_q.size());
        end
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT);
        $display("timeout");
        $display("Some tests failed");
        $finish;
    end

endmodule
